>>> rtl/core/tkjp_pkg.sv
`timescale 1ns / 1ps

package tkjp_pkg;

  // Parse phases of one object
  typedef enum logic [3:0] {
    PH_OPEN,
    PH_K1_OPEN,
    PH_K1_BODY,
    PH_COLON1,
    PH_V1_OPEN,
    PH_V1_BODY,
    PH_COMMA,
    PH_K2_OPEN,
    PH_K2_BODY,
    PH_COLON2,
    PH_V2_OPEN,
    PH_V2_BODY,
    PH_CLOSE,
    PH_DONE
  } phase_e;

  // Result kinds
  localparam logic [1:0] KIND_VALUE    = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNEXP_CHAR = 2'd1;
  localparam logic [1:0] ERR_UNEXP_KEY  = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED  = 2'd3;

  // Token bytes
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  // Key lengths
  localparam logic [2:0] LEN_TOPIC   = 3'd5;
  localparam logic [2:0] LEN_CONTENT = 3'd7;
  localparam logic [2:0] LEN_ACTION  = 3'd6;

  // Candidate mask bits
  localparam int unsigned CAND_TOPIC  = 0;
  localparam int unsigned CAND_SECOND = 1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic       field_tag;
    logic [7:0] value_byte;
    logic [1:0] error_code;
  } out_item_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) ||
           (b == 8'h0D) || (b == 8'h0C) || (b == 8'h0B);
  endfunction

  function automatic logic [7:0] topic_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h74; // t
      3'd1:    c = 8'h6F; // o
      3'd2:    c = 8'h70; // p
      3'd3:    c = 8'h69; // i
      3'd4:    c = 8'h63; // c
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] second_char(input logic mode, input logic [2:0] idx);
    logic [7:0] c;
    if (mode) begin
      case (idx)
        3'd0:    c = 8'h61; // a
        3'd1:    c = 8'h63; // c
        3'd2:    c = 8'h74; // t
        3'd3:    c = 8'h69; // i
        3'd4:    c = 8'h6F; // o
        3'd5:    c = 8'h6E; // n
        default: c = 8'h00;
      endcase
    end else begin
      case (idx)
        3'd0:    c = 8'h63; // c
        3'd1:    c = 8'h6F; // o
        3'd2:    c = 8'h6E; // n
        3'd3:    c = 8'h74; // t
        3'd4:    c = 8'h65; // e
        3'd5:    c = 8'h6E; // n
        3'd6:    c = 8'h74; // t
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

  function automatic phase_e next_phase(input phase_e ph);
    phase_e n;
    case (ph)
      PH_OPEN:    n = PH_K1_OPEN;
      PH_K1_OPEN: n = PH_K1_BODY;
      PH_K1_BODY: n = PH_COLON1;
      PH_COLON1:  n = PH_V1_OPEN;
      PH_V1_OPEN: n = PH_V1_BODY;
      PH_V1_BODY: n = PH_COMMA;
      PH_COMMA:   n = PH_K2_OPEN;
      PH_K2_OPEN: n = PH_K2_BODY;
      PH_K2_BODY: n = PH_COLON2;
      PH_COLON2:  n = PH_V2_OPEN;
      PH_V2_OPEN: n = PH_V2_BODY;
      PH_V2_BODY: n = PH_CLOSE;
      PH_CLOSE:   n = PH_DONE;
      default:    n = PH_DONE;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/core/two_key_json_object_parser.sv
`timescale 1ns / 1ps

// Two-key object parser: takes one byte of object text per beat and checks the form
// {"key":"v","key":"v"}, each key "topic" or the second key, "content" (schema_mode
// 0) or "action" (schema_mode 1). Each value byte leaves as a value beat tagged
// with its field; the closing brace gives a complete beat and any fault an error
// beat, after which bytes up to end_of_text are dropped. A byte marked
// end_of_text that does not finish the object gives a truncated error. The block
// takes one byte every cycle, since each byte needs only one short parse step
// between the input register and the result register. A byte's result enters
// the result register as the byte leaves the input stage and stays until taken.
// While a result waits at the output, a byte that gives another result is held in
// the input register and the input stalls until the waiting beat leaves. Write
// schema_mode only while the block is idle.
module two_key_json_object_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tkjp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tkjp_pkg::out_item_t out_item_o
);

  logic                schema_mode_q;
  logic                s1_valid;
  tkjp_pkg::in_item_t  s1_item;
  logic                has_result;
  tkjp_pkg::out_item_t result;
  logic                advance;
  logic                out_valid_q, out_valid_d;
  tkjp_pkg::out_item_t out_item_q;

  // Hold the schema register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      schema_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      schema_mode_q <= cfg_wdata_i;
    end
  end

  tkjp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .pop_i      (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  // Advance a byte when its result has room or it gives none
  assign advance = s1_valid && (!has_result || !out_valid_q || out_ready_i);

  tkjp_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .item_i        (s1_item),
    .schema_mode_i (schema_mode_q),
    .has_result_o  (has_result),
    .result_o      (result)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance && has_result) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> rtl/core/tkjp_in_stage.sv
`timescale 1ns / 1ps

module tkjp_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tkjp_pkg::in_item_t in_item_i,
  input  logic               pop_i,
  output logic               valid_o,
  output tkjp_pkg::in_item_t item_o
);

  logic               valid_q;
  logic               valid_d;
  tkjp_pkg::in_item_t item_q;

  // Take a new beat when empty or when the held one leaves this cycle
  assign in_ready_o = !valid_q || pop_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on acceptance
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> rtl/core/tkjp_parse.sv
`timescale 1ns / 1ps

module tkjp_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  tkjp_pkg::in_item_t  item_i,
  input  logic                schema_mode_i,
  output logic                has_result_o,
  output tkjp_pkg::out_item_t result_o
);

  tkjp_pkg::phase_e phase_q, phase_d;
  logic [2:0]       idx_q, idx_d;
  logic [1:0]       cand_q, cand_d;
  logic             field_q, field_d;

  logic [7:0] b;
  logic       last;
  logic [7:0] tok;
  logic [2:0] sec_len;
  logic       emit_value, emit_done, emit_err, trunc;
  logic [1:0] err_code;

  assign b       = item_i.text_byte;
  assign last    = item_i.end_of_text;
  assign sec_len = schema_mode_i ? tkjp_pkg::LEN_ACTION : tkjp_pkg::LEN_CONTENT;

  // Pick the token expected by a punctuation phase
  always_comb begin
    case (phase_q)
      tkjp_pkg::PH_OPEN:  tok = tkjp_pkg::CH_LBRACE;
      tkjp_pkg::PH_COMMA: tok = tkjp_pkg::CH_COMMA;
      tkjp_pkg::PH_CLOSE: tok = tkjp_pkg::CH_RBRACE;
      default:            tok = tkjp_pkg::CH_COLON;
    endcase
  end

  // Advance the parse by one byte
  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    cand_d     = cand_q;
    field_d    = field_q;
    emit_value = 1'b0;
    emit_done  = 1'b0;
    emit_err   = 1'b0;
    err_code   = tkjp_pkg::ERR_NONE;

    case (phase_q)
      tkjp_pkg::PH_OPEN, tkjp_pkg::PH_COLON1, tkjp_pkg::PH_COMMA,
      tkjp_pkg::PH_COLON2, tkjp_pkg::PH_CLOSE: begin
        if (b == tok) begin
          if (phase_q == tkjp_pkg::PH_CLOSE) begin
            emit_done = 1'b1;
            phase_d   = tkjp_pkg::PH_DONE;
          end else begin
            phase_d = tkjp_pkg::next_phase(phase_q);
          end
        end else if (!tkjp_pkg::is_space(b)) begin
          emit_err = 1'b1;
          err_code = tkjp_pkg::ERR_UNEXP_CHAR;
        end
      end
      tkjp_pkg::PH_K1_OPEN, tkjp_pkg::PH_K2_OPEN,
      tkjp_pkg::PH_V1_OPEN, tkjp_pkg::PH_V2_OPEN: begin
        if (b == tkjp_pkg::CH_QUOTE) begin
          idx_d   = 3'd0;
          cand_d  = 2'b11;
          phase_d = tkjp_pkg::next_phase(phase_q);
        end else if (!tkjp_pkg::is_space(b)) begin
          emit_err = 1'b1;
          err_code = tkjp_pkg::ERR_UNEXP_CHAR;
        end
      end
      tkjp_pkg::PH_K1_BODY, tkjp_pkg::PH_K2_BODY: begin
        if (b == tkjp_pkg::CH_QUOTE) begin
          // Judge the key at its closing quote
          if (cand_q[tkjp_pkg::CAND_TOPIC] && (idx_q == tkjp_pkg::LEN_TOPIC)) begin
            field_d = 1'b0;
            phase_d = tkjp_pkg::next_phase(phase_q);
          end else if (cand_q[tkjp_pkg::CAND_SECOND] && (idx_q == sec_len)) begin
            field_d = 1'b1;
            phase_d = tkjp_pkg::next_phase(phase_q);
          end else begin
            emit_err = 1'b1;
            err_code = tkjp_pkg::ERR_UNEXP_KEY;
          end
        end else begin
          // Drop candidates that this byte rules out
          if ((idx_q >= tkjp_pkg::LEN_TOPIC) || (tkjp_pkg::topic_char(idx_q) != b)) begin
            cand_d[tkjp_pkg::CAND_TOPIC] = 1'b0;
          end
          if ((idx_q >= sec_len) || (tkjp_pkg::second_char(schema_mode_i, idx_q) != b)) begin
            cand_d[tkjp_pkg::CAND_SECOND] = 1'b0;
          end
          if (idx_q != 3'd7) begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      tkjp_pkg::PH_V1_BODY, tkjp_pkg::PH_V2_BODY: begin
        if (b == tkjp_pkg::CH_QUOTE) begin
          phase_d = tkjp_pkg::next_phase(phase_q);
        end else begin
          emit_value = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (emit_err) begin
      phase_d = tkjp_pkg::PH_DONE;
    end

    // Flag an object that ends before it is finished
    trunc = last && !emit_done && !emit_err && (phase_q != tkjp_pkg::PH_DONE);

    if (last) begin
      phase_d = tkjp_pkg::PH_OPEN;
      idx_d   = 3'd0;
      cand_d  = 2'b11;
      field_d = 1'b0;
    end

    // Form the result beat
    result_o     = '0;
    has_result_o = 1'b1;
    if (emit_err || trunc) begin
      result_o.result_kind = tkjp_pkg::KIND_ERROR;
      result_o.error_code  = trunc ? tkjp_pkg::ERR_TRUNCATED : err_code;
    end else if (emit_done) begin
      result_o.result_kind = tkjp_pkg::KIND_COMPLETE;
    end else if (emit_value) begin
      result_o.result_kind = tkjp_pkg::KIND_VALUE;
      result_o.field_tag   = field_q;
      result_o.value_byte  = b;
    end else begin
      has_result_o = 1'b0;
    end
  end

  // Hold parse state between beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tkjp_pkg::PH_OPEN;
      idx_q   <= 3'd0;
      cand_q  <= 2'b11;
      field_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      cand_q  <= cand_d;
      field_q <= field_d;
    end
  end

  // End of text always returns the parser to the opening brace
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last |=> phase_q == tkjp_pkg::PH_OPEN && cand_q == 2'b11 && idx_q == 3'd0)
    else $error("parse state not cleared after end of text");

  // Nothing more comes out once an object is finished
  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == tkjp_pkg::PH_DONE && !last |-> !has_result_o)
    else $error("result emitted after object finished");

  // An error beat always carries a real code
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && has_result_o && result_o.result_kind == tkjp_pkg::KIND_ERROR
    |-> result_o.error_code != tkjp_pkg::ERR_NONE)
    else $error("error beat without error code");

  // Completion or error mid-text parks the parser
  a_finish_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && has_result_o && !last && result_o.result_kind != tkjp_pkg::KIND_VALUE
    |=> phase_q == tkjp_pkg::PH_DONE)
    else $error("parser not parked after finishing");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_LIMIT = 5000;

  // Tracks the parse of one object at a time and holds the beats it should give
  class parse_scoreboard;
    tkjp_pkg::phase_e    phase;
    logic [2:0]          key_len;
    logic [1:0]          key_cand;
    logic                field;
    logic                done;
    logic                schema;
    string               topic_name;
    string               second_name [2];
    tkjp_pkg::out_item_t pending_results [$];
    int unsigned         mismatches;
    int unsigned         value_beats;
    int unsigned         complete_beats;
    int unsigned         error_beats;

    function new();
      topic_name     = "topic";
      second_name[0] = "content";
      second_name[1] = "action";
      schema         = 1'b0;
      mismatches     = 0;
      value_beats    = 0;
      complete_beats = 0;
      error_beats    = 0;
      clear_object();
    endfunction

    function void clear_object();
      phase    = tkjp_pkg::PH_OPEN;
      key_len  = '0;
      key_cand = 2'b11;
      field    = 1'b0;
      done     = 1'b0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function bit blank(logic [7:0] b);
      return b == 8'h20 || b == 8'h09 || b == 8'h0A ||
             b == 8'h0D || b == 8'h0C || b == 8'h0B;
    endfunction

    // Advance the parse by one accepted byte and queue the beat it causes
    function void take_byte(tkjp_pkg::in_item_t beat);
      logic [7:0]          b;
      logic [7:0]          tok;
      logic [2:0]          slen;
      logic [1:0]          code;
      bit                  emit_val;
      bit                  emit_end;
      bit                  emit_err;
      tkjp_pkg::out_item_t r;
      b        = beat.text_byte;
      code     = tkjp_pkg::ERR_NONE;
      emit_val = 1'b0;
      emit_end = 1'b0;
      emit_err = 1'b0;
      case (phase)
        tkjp_pkg::PH_OPEN, tkjp_pkg::PH_COLON1, tkjp_pkg::PH_COMMA,
        tkjp_pkg::PH_COLON2, tkjp_pkg::PH_CLOSE: begin
          if (phase == tkjp_pkg::PH_OPEN) tok = tkjp_pkg::CH_LBRACE;
          else if (phase == tkjp_pkg::PH_COMMA) tok = tkjp_pkg::CH_COMMA;
          else if (phase == tkjp_pkg::PH_CLOSE) tok = tkjp_pkg::CH_RBRACE;
          else tok = tkjp_pkg::CH_COLON;
          if (b == tok) begin
            if (phase == tkjp_pkg::PH_CLOSE) begin
              emit_end = 1'b1;
              phase    = tkjp_pkg::PH_DONE;
              done     = 1'b1;
            end else begin
              phase = tkjp_pkg::phase_e'(phase + 4'd1);
            end
          end else if (!blank(b)) begin
            emit_err = 1'b1;
            code     = tkjp_pkg::ERR_UNEXP_CHAR;
          end
        end
        tkjp_pkg::PH_K1_OPEN, tkjp_pkg::PH_K2_OPEN,
        tkjp_pkg::PH_V1_OPEN, tkjp_pkg::PH_V2_OPEN: begin
          if (b == tkjp_pkg::CH_QUOTE) begin
            key_len  = '0;
            key_cand = 2'b11;
            phase    = tkjp_pkg::phase_e'(phase + 4'd1);
          end else if (!blank(b)) begin
            emit_err = 1'b1;
            code     = tkjp_pkg::ERR_UNEXP_CHAR;
          end
        end
        tkjp_pkg::PH_K1_BODY, tkjp_pkg::PH_K2_BODY: begin
          slen = schema ? tkjp_pkg::LEN_ACTION : tkjp_pkg::LEN_CONTENT;
          if (b == tkjp_pkg::CH_QUOTE) begin
            // judge the key at its closing quote
            if (key_cand[tkjp_pkg::CAND_TOPIC] && key_len == tkjp_pkg::LEN_TOPIC) begin
              field = 1'b0;
              phase = tkjp_pkg::phase_e'(phase + 4'd1);
            end else if (key_cand[tkjp_pkg::CAND_SECOND] && key_len == slen) begin
              field = 1'b1;
              phase = tkjp_pkg::phase_e'(phase + 4'd1);
            end else begin
              emit_err = 1'b1;
              code     = tkjp_pkg::ERR_UNEXP_KEY;
            end
          end else begin
            if (key_len >= tkjp_pkg::LEN_TOPIC || topic_name[key_len] != b) begin
              key_cand[tkjp_pkg::CAND_TOPIC] = 1'b0;
            end
            if (key_len >= slen || second_name[schema][key_len] != b) begin
              key_cand[tkjp_pkg::CAND_SECOND] = 1'b0;
            end
            if (key_len != 3'd7) key_len = key_len + 3'd1;
          end
        end
        tkjp_pkg::PH_V1_BODY, tkjp_pkg::PH_V2_BODY: begin
          if (b == tkjp_pkg::CH_QUOTE) phase = tkjp_pkg::phase_e'(phase + 4'd1);
          else emit_val = 1'b1;
        end
        default: ;
      endcase

      if (emit_err) begin
        phase = tkjp_pkg::PH_DONE;
        done  = 1'b1;
      end

      // End of text that neither completes nor faults means truncation
      if (beat.end_of_text && !emit_end && !emit_err && !done) begin
        emit_err = 1'b1;
        emit_val = 1'b0;
        code     = tkjp_pkg::ERR_TRUNCATED;
      end

      r = '0;
      if (emit_err) begin
        r.result_kind = tkjp_pkg::KIND_ERROR;
        r.error_code  = code;
        pending_results.push_back(r);
      end else if (emit_end) begin
        r.result_kind = tkjp_pkg::KIND_COMPLETE;
        pending_results.push_back(r);
      end else if (emit_val) begin
        r.result_kind = tkjp_pkg::KIND_VALUE;
        r.field_tag   = field;
        r.value_byte  = b;
        pending_results.push_back(r);
      end

      if (beat.end_of_text) clear_object();
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Compare an output beat with the oldest queued beat
    task check_beat(tkjp_pkg::out_item_t got);
      tkjp_pkg::out_item_t want;
      string               bad;
      case (got.result_kind)
        tkjp_pkg::KIND_VALUE:    value_beats++;
        tkjp_pkg::KIND_COMPLETE: complete_beats++;
        default:                 error_beats++;
      endcase
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("beat with nothing queued: kind %0d tag %0d byte %02h code %0d",
                                  got.result_kind, got.field_tag, got.value_byte,
                                  got.error_code));
      end else begin
        want = pending_results.pop_front();
        bad  = "";
        if (got.result_kind !== want.result_kind) bad = {bad, " kind"};
        if (got.field_tag !== want.field_tag) bad = {bad, " tag"};
        if (got.value_byte !== want.value_byte) bad = {bad, " byte"};
        if (got.error_code !== want.error_code) bad = {bad, " code"};
        if (bad != "") begin
          report_mismatch($sformatf("beat differs in%s: got %0d/%0d/%02h/%0d want %0d/%0d/%02h/%0d",
                                    bad, got.result_kind, got.field_tag, got.value_byte,
                                    got.error_code, want.result_kind, want.field_tag,
                                    want.value_byte, want.error_code));
        end
      end
    endtask

    task flush_leftovers();
      tkjp_pkg::out_item_t want;
      while (pending_results.size() != 0) begin
        want = pending_results.pop_front();
        report_mismatch($sformatf("beat never arrived: kind %0d tag %0d byte %02h code %0d",
                                  want.result_kind, want.field_tag, want.value_byte,
                                  want.error_code));
      end
    endtask
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic                cfg_wdata_i = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  tkjp_pkg::in_item_t  in_item_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  tkjp_pkg::out_item_t out_item_o;

  parse_scoreboard sb = new();

  logic [7:0]  text_q [$];
  int unsigned src_gap_pct    = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned bytes_sent     = 0;
  int unsigned objects_sent   = 0;
  int unsigned schema_writes  = 0;
  int unsigned full_drains    = 0;

  two_key_json_object_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[%0t] run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // Watch both channels; values seen here are those before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.take_byte(in_item_i);
      if (out_valid_o && out_ready_i) sb.check_beat(out_item_o);
    end
  end

  // Stall the result side in random bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Offer one byte; optionally idle first, or hold until every beat is back
  task automatic send_byte(input logic [7:0] b, input logic eot, input bit hold);
    int unsigned        gap;
    tkjp_pkg::in_item_t beat;
    gap = 0;
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) gap = $urandom_range(1, 18);
    if (hold && gap == 0) gap = 1;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (hold) begin
        while (sb.pending() != 0) @(posedge clk_i);
        full_drains++;
      end
    end
    beat.text_byte   = b;
    beat.end_of_text = eot;
    in_item_i  <= beat;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_text(input int hold_pos);
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1, i == hold_pos);
    end
    objects_sent++;
  endtask

  // Let the block empty out, then allow for its pipeline
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    full_drains++;
  endtask

  task automatic set_schema(input logic mode);
    drain_pipe();
    cfg_wdata_i <= mode;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.schema    = mode;
    schema_writes++;
  endtask

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0:       return 8'h20;
      1:       return 8'h09;
      2:       return 8'h0A;
      3:       return 8'h0D;
      4:       return 8'h0C;
      default: return 8'h0B;
    endcase
  endfunction

  function automatic void push_blank();
    int unsigned n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) text_q.push_back(pick_blank());
  endfunction

  function automatic logic [7:0] any_but_quote();
    logic [7:0] b;
    b = 8'($urandom);
    while (b == tkjp_pkg::CH_QUOTE) b = 8'($urandom);
    return b;
  endfunction

  // Mostly the two valid names, now and then a near miss or junk
  function automatic void push_key();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 19);
    if (pick < 9) begin
      push_str("topic");
    end else if (pick < 18) begin
      if (sb.schema) push_str("action");
      else push_str("content");
    end else begin
      case ($urandom_range(0, 7))
        0: begin
          if (sb.schema) push_str("content");
          else push_str("action");
        end
        1: push_str("topi");
        2: push_str("topics");
        3: ;
        4: push_str("contents");
        5: push_str("actio");
        6: push_str("topictopic");
        default: begin
          n = $urandom_range(1, 9);
          repeat (n) text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
        end
      endcase
    end
  endfunction

  function automatic void push_value();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 5);
    text_q.push_back(tkjp_pkg::CH_QUOTE);
    repeat (n) text_q.push_back(any_but_quote());
    text_q.push_back(tkjp_pkg::CH_QUOTE);
  endfunction

  function automatic void push_pair();
    push_blank();
    text_q.push_back(tkjp_pkg::CH_QUOTE);
    push_key();
    text_q.push_back(tkjp_pkg::CH_QUOTE);
    push_blank();
    text_q.push_back(tkjp_pkg::CH_COLON);
    push_blank();
    push_value();
    push_blank();
  endfunction

  // Build one object: mostly well formed, the rest damaged or noise
  function automatic void build_object();
    int unsigned pick;
    int unsigned pos;
    int unsigned n;
    text_q.delete();
    push_blank();
    text_q.push_back(tkjp_pkg::CH_LBRACE);
    push_pair();
    text_q.push_back(tkjp_pkg::CH_COMMA);
    push_pair();
    text_q.push_back(tkjp_pkg::CH_RBRACE);
    pick = $urandom_range(0, 99);
    pos  = $urandom_range(0, text_q.size() - 2);
    if (pick < 60) begin
      // trailing bytes after the brace are dropped by the block
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) text_q.push_back(8'($urandom));
      end
    end else if (pick < 72) begin
      text_q[pos] = 8'($urandom);
    end else if (pick < 82) begin
      while (text_q.size() > pos + 1) void'(text_q.pop_back());
    end else if (pick < 92) begin
      text_q.insert(pos, 8'($urandom));
    end else begin
      text_q.delete();
      n = $urandom_range(1, 8);
      repeat (n) text_q.push_back(8'($urandom));
    end
  endfunction

  task automatic run_objects(input int unsigned goal, input bit allow_hold, input bit force_hold);
    int unsigned start;
    int          hold_pos;
    start = bytes_sent;
    while (bytes_sent - start < goal) begin
      build_object();
      hold_pos = -1;
      if (force_hold || (allow_hold && $urandom_range(0, 7) == 0)) begin
        hold_pos = $urandom_range(0, text_q.size() - 1);
      end
      force_hold = 1'b0;
      send_text(hold_pos);
    end
  endtask

  initial begin
    int unsigned n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: stray bytes at the range ends, truncation, bad keys, after finish
    src_gap_pct    = 30;
    sink_stall_pct = 5;
    text_q.delete();
    text_q.push_back(8'h00);
    send_text(-1);
    text_q.delete();
    text_q.push_back(8'hFF);
    send_text(-1);
    text_q.delete();
    text_q.push_back(tkjp_pkg::CH_LBRACE);
    send_text(-1);
    text_q.delete();
    text_q.push_back(8'h0B);
    send_text(-1);
    text_q.delete();
    push_str("{\"x\"");
    send_text(-1);
    text_q.delete();
    push_str("{\"\"");
    send_text(-1);
    text_q.delete();
    push_str("q}{");
    send_text(-1);
    text_q.delete();
    push_str("{\"topic\":\"ab");
    send_text(-1);

    // Random objects under several schema and idling settings
    set_schema(1'b1);
    src_gap_pct    = 20;
    sink_stall_pct = 5;
    run_objects(200, 1'b1, 1'b1);

    set_schema(1'b0);
    src_gap_pct    = 40;
    sink_stall_pct = 0;
    run_objects(200, 1'b1, 1'b0);

    set_schema(1'b1);
    src_gap_pct    = 0;
    sink_stall_pct = 12;
    run_objects(200, 1'b1, 1'b0);

    // Closing stretch at full rate on both sides
    set_schema(1'b0);
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    run_objects(200, 1'b0, 1'b0);

    // Wait out the remaining beats
    in_valid_i <= 1'b0;
    n = 0;
    @(posedge clk_i);
    while (n < DRAIN_LIMIT && sb.pending() != 0) begin
      @(posedge clk_i);
      n++;
    end
    repeat (8) @(posedge clk_i);
    sb.flush_leftovers();

    $display("covered %0d bytes in %0d objects: %0d value, %0d complete, %0d error beats",
             bytes_sent, objects_sent, sb.value_beats, sb.complete_beats, sb.error_beats);
    $display("content and action key schemas both used: %0d schema writes, %0d full drains",
             schema_writes, full_drains);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/tkjp_pkg.sv
rtl/core/tkjp_in_stage.sv
rtl/core/tkjp_parse.sv
rtl/core/two_key_json_object_parser.sv
sim/testbench.sv
